/* rtl/core/fqs_pkg.sv */
// ----------------------------------------------------------------------------
// fqs_pkg: shared types and constants
// Transaction payloads, controller states and the command/status bundles that
// join the multilevel feedback scheduler controller and datapath.
// ----------------------------------------------------------------------------
package fqs_pkg;

   localparam int ID_W        = 4;
   localparam int WORK_W      = 8;
   localparam int LEVEL_OUT_W = 3;
   localparam int ID_COUNT    = 1 << ID_W;

   localparam logic FUNC_ADMIT = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   typedef struct packed {
      logic              func;
      logic [ID_W-1:0]   proc_id;
      logic [WORK_W-1:0] service_time;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]        run_id;
      logic                   idle;
      logic                   done_res;
      logic [LEVEL_OUT_W-1:0] run_level;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADMIT,
      ST_REQUEUE,
      ST_SELECT,
      ST_POP,
      ST_RUN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic do_admit;
      logic do_requeue;
      logic do_select;
      logic do_pop;
      logic do_run;
      logic do_emit;
   } cmd_type;

   typedef struct packed {
      logic item_func;
      logic cur_valid;
      logic any_waiting;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/feedback_queue_scheduler_pow2_quantum_core.sv */
// ----------------------------------------------------------------------------
// feedback_queue_scheduler_pow2_quantum_core: multilevel feedback scheduler
// Admit transactions queue a process at level 0; tick transactions run one
// time unit with a quantum of 2^level and report the running process.
// Sequence: a tick passes through admit, requeue, select, pop when a process is
// dequeued, run and emit; an idle tick skips pop and run; an admit gives no result.
// One transaction at a time: a new request is taken only back in idle, and the
// emit step waits on rsp_ready while the output register still holds a result.
// Reset: queues empty, no process running, output register empty.
// ----------------------------------------------------------------------------
module feedback_queue_scheduler_pow2_quantum_core #(
   parameter int NUM_PROCS  = 16,
   parameter int NUM_LEVELS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fqs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fqs_pkg::rsp_type rsp_data
);

   fqs_pkg::cmd_type    cmd;
   fqs_pkg::status_type status;

   fqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   fqs_datapath #(
      .NUM_PROCS  (NUM_PROCS),
      .NUM_LEVELS (NUM_LEVELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_step_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.do_admit, cmd.do_requeue, cmd.do_select,
                cmd.do_pop, cmd.do_run, cmd.do_emit}))
      else $error("more than one datapath step issued");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.do_emit |-> status.out_free)
      else $error("result loaded over an untaken transaction");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new transaction taken before the previous one was processed");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.do_emit |=> rsp_valid)
      else $error("emitted result not presented");

endmodule

/* rtl/core/fqs_ctrl.sv */
// ----------------------------------------------------------------------------
// fqs_ctrl: scheduler sequencer
// Steps one transaction through admit, then for a tick requeue, select, pop and run as needed, and emit.
// ----------------------------------------------------------------------------
module fqs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  fqs_pkg::status_type status,
   output logic               req_ready,
   output fqs_pkg::cmd_type   cmd
);

   fqs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fqs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fqs_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fqs_pkg::ST_ADMIT;
            end
         end
         fqs_pkg::ST_ADMIT: begin
            // latched item decides the path
            if (status.item_func == fqs_pkg::FUNC_TICK) begin
               state_in = fqs_pkg::ST_REQUEUE;
            end else begin
               state_in = fqs_pkg::ST_IDLE;
            end
         end
         fqs_pkg::ST_REQUEUE: state_in = fqs_pkg::ST_SELECT;
         fqs_pkg::ST_SELECT: begin
            if (status.cur_valid) begin
               state_in = fqs_pkg::ST_RUN;
            end else if (status.any_waiting) begin
               state_in = fqs_pkg::ST_POP;
            end else begin
               state_in = fqs_pkg::ST_EMIT;
            end
         end
         fqs_pkg::ST_POP:  state_in = fqs_pkg::ST_RUN;
         fqs_pkg::ST_RUN:  state_in = fqs_pkg::ST_EMIT;
         fqs_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = fqs_pkg::ST_IDLE;
            end
         end
         default: state_in = fqs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         fqs_pkg::ST_IDLE: begin
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
         end
         fqs_pkg::ST_ADMIT:   cmd.do_admit   = (status.item_func == fqs_pkg::FUNC_ADMIT);
         fqs_pkg::ST_REQUEUE: cmd.do_requeue = 1'b1;
         fqs_pkg::ST_SELECT:  cmd.do_select  = 1'b1;
         fqs_pkg::ST_POP:     cmd.do_pop     = 1'b1;
         fqs_pkg::ST_RUN:     cmd.do_run     = 1'b1;
         fqs_pkg::ST_EMIT:    cmd.do_emit    = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

/* rtl/core/fqs_datapath.sv */
// ----------------------------------------------------------------------------
// fqs_datapath: level queues, work store and result register
// Circular queues per level in one memory, remaining work per id, the running
// process context and the output register.
// ----------------------------------------------------------------------------
module fqs_datapath #(
   parameter int NUM_PROCS  = 16,
   parameter int NUM_LEVELS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  fqs_pkg::req_type    req_data,
   input  fqs_pkg::cmd_type    cmd,
   output fqs_pkg::status_type status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output fqs_pkg::rsp_type    rsp_data
);

   localparam int SW    = $clog2(NUM_PROCS);
   localparam int CW    = $clog2(NUM_PROCS + 1);
   localparam int LW    = $clog2(NUM_LEVELS);
   localparam int QW    = NUM_LEVELS;
   localparam int DEPTH = NUM_LEVELS << SW;
   localparam int AW    = LW + SW;

   fqs_pkg::req_type item_ff;

   logic [SW-1:0] head_ff  [NUM_LEVELS];
   logic [CW-1:0] count_ff [NUM_LEVELS];

   logic [fqs_pkg::ID_W-1:0]   fifo_mem [DEPTH];
   logic [fqs_pkg::ID_W-1:0]   fifo_rdata_ff;
   logic [fqs_pkg::WORK_W-1:0] work_mem [fqs_pkg::ID_COUNT];
   logic [fqs_pkg::WORK_W-1:0] work_rdata_ff;

   logic [fqs_pkg::ID_W-1:0] cur_id_ff;
   logic [LW-1:0]            cur_level_ff;
   logic [QW-1:0]            qleft_ff;
   logic                     cur_valid_ff;

   fqs_pkg::rsp_type res_ff;
   fqs_pkg::rsp_type rsp_data_ff;
   logic             rsp_valid_ff;

   logic [NUM_LEVELS-1:0] nonempty;
   logic                  any_waiting;
   logic [LW-1:0]         first_lvl;
   logic                  admit_ok;
   logic                  expired;
   logic [LW-1:0]         requeue_lvl;
   logic                  push_req;
   logic                  push_en;
   logic [LW-1:0]         push_lvl;
   logic [fqs_pkg::ID_W-1:0] push_id;
   logic [SW:0]           tail_sum;
   logic [SW-1:0]         tail;
   logic                  pop_en;
   logic [SW-1:0]         head_next;
   logic [AW-1:0]         fifo_raddr;
   logic [fqs_pkg::ID_W-1:0] work_raddr;
   logic                  work_we;
   logic [fqs_pkg::ID_W-1:0] work_waddr;
   logic [fqs_pkg::WORK_W-1:0] work_wdata;
   logic [fqs_pkg::WORK_W-1:0] work_left;
   logic [LW+fqs_pkg::LEVEL_OUT_W-1:0] level_ext;

   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         nonempty[i] = (count_ff[i] != '0);
      end
   end

   assign any_waiting = |nonempty;

   always_comb begin
      first_lvl = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            first_lvl = LW'(i);
         end
      end
   end

   assign admit_ok = (item_ff.service_time != '0) && (32'(item_ff.proc_id) < NUM_PROCS);
   assign expired  = cur_valid_ff && (qleft_ff == '0);

   assign requeue_lvl = (any_waiting && (cur_level_ff != LW'(NUM_LEVELS - 1))) ?
                        cur_level_ff + LW'(1) : cur_level_ff;

   assign push_req = (cmd.do_admit && admit_ok) || (cmd.do_requeue && expired);
   assign push_lvl = cmd.do_admit ? '0 : requeue_lvl;
   assign push_id  = cmd.do_admit ? item_ff.proc_id : cur_id_ff;
   assign push_en  = push_req && (count_ff[push_lvl] < CW'(NUM_PROCS));

   assign tail_sum = {1'b0, head_ff[push_lvl]} + (SW+1)'(count_ff[push_lvl]);
   assign tail     = (tail_sum >= (SW+1)'(NUM_PROCS)) ?
                     SW'(tail_sum - (SW+1)'(NUM_PROCS)) : tail_sum[SW-1:0];

   assign pop_en    = cmd.do_select && !cur_valid_ff && any_waiting;
   assign head_next = (head_ff[first_lvl] == SW'(NUM_PROCS - 1)) ?
                      '0 : head_ff[first_lvl] + SW'(1);
   assign fifo_raddr = {first_lvl, head_ff[first_lvl]};

   assign work_raddr = cmd.do_pop ? fifo_rdata_ff : cur_id_ff;
   assign work_left  = (work_rdata_ff != '0) ? work_rdata_ff - 8'd1 : '0;

   assign work_we    = cmd.do_admit ? push_en : cmd.do_run;
   assign work_waddr = cmd.do_admit ? item_ff.proc_id : cur_id_ff;
   assign work_wdata = cmd.do_admit ? item_ff.service_time : work_left;

   assign level_ext = {{fqs_pkg::LEVEL_OUT_W{1'b0}}, cur_level_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         fifo_mem[{push_lvl, tail}] <= push_id;
      end
      fifo_rdata_ff <= fifo_mem[fifo_raddr];
   end

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[work_waddr] <= work_wdata;
      end
      work_rdata_ff <= work_mem[work_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (push_en) begin
         count_ff[push_lvl] <= count_ff[push_lvl] + CW'(1);
      end else if (pop_en) begin
         head_ff[first_lvl]  <= head_next;
         count_ff[first_lvl] <= count_ff[first_lvl] - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_id_ff    <= '0;
         cur_level_ff <= '0;
         qleft_ff     <= '0;
         cur_valid_ff <= 1'b0;
      end else begin
         if (cmd.do_requeue && expired) begin
            cur_valid_ff <= 1'b0;
         end
         if (pop_en) begin
            cur_level_ff <= first_lvl;
            qleft_ff     <= QW'(1) << first_lvl;
            cur_valid_ff <= 1'b1;
         end
         if (cmd.do_pop) begin
            cur_id_ff <= fifo_rdata_ff;
         end
         if (cmd.do_run) begin
            if (work_left == '0) begin
               cur_valid_ff <= 1'b0;
               qleft_ff     <= '0;
            end else begin
               qleft_ff <= qleft_ff - QW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_select && !cur_valid_ff && !any_waiting) begin
         res_ff.run_id    <= '0;
         res_ff.idle      <= 1'b1;
         res_ff.done_res  <= 1'b0;
         res_ff.run_level <= '0;
      end else if (cmd.do_run) begin
         res_ff.run_id    <= cur_id_ff;
         res_ff.idle      <= 1'b0;
         res_ff.done_res  <= (work_left == '0);
         res_ff.run_level <= level_ext[fqs_pkg::LEVEL_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.do_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_emit) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.item_func   = item_ff.func;
   assign status.cur_valid   = cur_valid_ff;
   assign status.any_waiting = any_waiting;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for feedback_queue_scheduler_pow2_quantum_core
// Drives admit and tick transactions through the request channel. A scheduler
// model predicts each tick report, and the reports are checked in order on the
// response channel. Both channels see random idle and stall bursts.
// ----------------------------------------------------------------------------
module tb;

   localparam int NUM_PROCS  = 16;
   localparam int NUM_LEVELS = 8;

   typedef logic [fqs_pkg::ID_W-1:0] proc_id_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   fqs_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   fqs_pkg::rsp_type rsp_data;

   proc_id_type                level_store[NUM_LEVELS][NUM_PROCS];
   int                         level_count[NUM_LEVELS];
   logic [fqs_pkg::WORK_W-1:0] work_left[NUM_PROCS];
   proc_id_type                running_id;
   int                         running_level;
   int                         quantum_left;
   bit                         running_valid;

   fqs_pkg::rsp_type expected_reports[$];
   int               mismatch_count;
   int               sent_count;
   int               tick_count;
   int               admit_count;
   int               finish_count;
   int               idle_count;
   int               deepest_level;
   bit               idle_enable;

   feedback_queue_scheduler_pow2_quantum_core #(
      .NUM_PROCS (NUM_PROCS),
      .NUM_LEVELS(NUM_LEVELS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic schedule_step(input fqs_pkg::req_type req);
      fqs_pkg::rsp_type report;
      int               lvl;
      int               waiting;
      if (req.func == fqs_pkg::FUNC_ADMIT) begin
         if (req.service_time != 0 && req.proc_id < NUM_PROCS &&
             level_count[0] < NUM_PROCS) begin
            work_left[req.proc_id] = req.service_time;
            level_store[0][level_count[0]] = req.proc_id;
            level_count[0]++;
            admit_count++;
         end
         return;
      end
      tick_count++;
      if (running_valid && quantum_left == 0) begin
         lvl = running_level;
         waiting = 0;
         for (int l = 0; l < NUM_LEVELS; l++) waiting += level_count[l];
         if (waiting > 0 && lvl + 1 < NUM_LEVELS) lvl++;
         if (level_count[lvl] < NUM_PROCS) begin
            level_store[lvl][level_count[lvl]] = running_id;
            level_count[lvl]++;
         end
         running_valid = 1'b0;
      end
      report = '0;
      if (!running_valid) begin
         lvl = NUM_LEVELS;
         for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (level_count[l] > 0) lvl = l;
         end
         if (lvl == NUM_LEVELS) begin
            report.idle = 1'b1;
            idle_count++;
            expected_reports.push_back(report);
            return;
         end
         running_id = level_store[lvl][0];
         for (int k = 1; k < level_count[lvl]; k++) begin
            level_store[lvl][k-1] = level_store[lvl][k];
         end
         level_count[lvl]--;
         running_level = lvl;
         quantum_left = 1 << lvl;
         running_valid = 1'b1;
      end
      if (work_left[running_id] > 0) work_left[running_id]--;
      quantum_left--;
      if (work_left[running_id] == 0) begin
         report.done_res = 1'b1;
         running_valid = 1'b0;
         quantum_left = 0;
         finish_count++;
      end
      report.run_id = running_id;
      report.run_level = running_level[fqs_pkg::LEVEL_OUT_W-1:0];
      if (running_level > deepest_level) deepest_level = running_level;
      expected_reports.push_back(report);
   endtask

   function automatic fqs_pkg::req_type make_req(logic func, int pid, int svc);
      fqs_pkg::req_type req;
      req.func = func;
      req.proc_id = pid[fqs_pkg::ID_W-1:0];
      req.service_time = svc[fqs_pkg::WORK_W-1:0];
      return req;
   endfunction

   function automatic int pick_service();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(1, 6);
      if (r < 9) return $urandom_range(7, 40);
      return $urandom_range(41, 255);
   endfunction

   task automatic send_item(input fqs_pkg::req_type req);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      schedule_step(req);
      sent_count++;
   endtask

   task automatic send_admit(int pid, int svc);
      send_item(make_req(fqs_pkg::FUNC_ADMIT, pid, svc));
   endtask

   task automatic send_ticks(int count);
      repeat (count) send_item(make_req(fqs_pkg::FUNC_TICK, 0, 0));
   endtask

   task automatic test_idle_ticks();
      send_ticks(2);
   endtask

   task automatic test_admit_limits();
      send_admit(0, 0);
      send_admit(15, 255);
      send_admit(0, 1);
      send_admit(15, 1);
      send_ticks(4);
   endtask

   task automatic test_requeue_alone();
      send_admit(5, 3);
      send_ticks(4);
   endtask

   task automatic test_demotion();
      send_admit(3, 3);
      send_admit(9, 3);
      send_ticks(7);
   endtask

   task automatic test_level_saturation();
      send_admit(1, 255);
      send_admit(2, 140);
      send_ticks(400);
   endtask

   task automatic test_random_traffic();
      int kind;
      bit first;
      first = 1'b1;
      while (sent_count < 550) begin
         if (sent_count >= 470) idle_enable = 1'b0;
         kind = first ? 9 : $urandom_range(0, 9);
         first = 1'b0;
         if (kind < 7) begin
            repeat ($urandom_range(1, 5)) begin
               send_admit($urandom_range(0, 15), pick_service());
            end
            repeat ($urandom_range(1, 30)) begin
               if ($urandom_range(0, 7) == 0) begin
                  send_admit($urandom_range(0, 15), pick_service());
               end
               send_ticks(1);
            end
         end else if (kind < 9) begin
            repeat ($urandom_range(1, 8)) begin
               send_item(make_req(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                                  $urandom_range(0, 255)));
            end
         end else begin
            repeat (18) begin
               send_admit($urandom_range(0, 15), $urandom_range(2, 6));
            end
            repeat ($urandom_range(10, 40)) begin
               if ($urandom_range(0, 1) == 0) begin
                  send_admit($urandom_range(0, 15), pick_service());
               end
               send_ticks(1);
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      idle_enable = 1'b1;
      for (int l = 0; l < NUM_LEVELS; l++) level_count[l] = 0;
      running_id = '0;
      running_level = 0;
      quantum_left = 0;
      running_valid = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_ticks();
      test_admit_limits();
      test_requeue_alone();
      test_demotion();
      test_level_saturation();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Ran %0d ticks and %0d admits; %0d completions, %0d idle ticks.",
               tick_count, admit_count, finish_count, idle_count);
      $display("Deepest queue level that ran: %0d.", deepest_level);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      wait (!reset);
      @(posedge clock);
      forever begin
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : report_check
      fqs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected report: run_id=%0d idle=%0b done=%0b level=%0d",
                        rsp_data.run_id, rsp_data.idle, rsp_data.done_res,
                        rsp_data.run_level);
            end
         end else begin
            want = expected_reports.pop_front();
            if (rsp_data.run_id !== want.run_id || rsp_data.idle !== want.idle ||
                rsp_data.done_res !== want.done_res ||
                rsp_data.run_level !== want.run_level) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("report mismatch: expected run_id=%0d idle=%0b done=%0b level=%0d",
                           want.run_id, want.idle, want.done_res, want.run_level);
                  $display("                 actual   run_id=%0d idle=%0b done=%0b level=%0d",
                           rsp_data.run_id, rsp_data.idle, rsp_data.done_res,
                           rsp_data.run_level);
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Timed out waiting for transactions");
      $display("Mismatches found");
      $finish;
   end

endmodule
